// ----- rtl/tce_pkg.sv -----
// Shared constants, codes and types of the text terminal cursor editor.
// Depends on nothing; every other file but tce_ram imports it.
package tce_pkg;

   // screen geometry
   localparam int COLUMNS = 32;
   localparam int ROWS    = 30;
   localparam int CELLS   = COLUMNS * ROWS;
   localparam int CELL_W  = $clog2(CELLS);
   localparam int COL_W   = $clog2(COLUMNS);
   localparam int ROW_W   = $clog2(ROWS);

   // port field widths
   localparam int CHAR_W    = 8;
   localparam int ADDR_W    = 10;
   localparam int PHASE_W   = 2;
   localparam int CSR_W     = 8;
   localparam int CSR_IDX_W = 1;
   localparam int REQ_W     = 24;
   localparam int RSP_W     = 24;

   // character codes
   localparam logic [CHAR_W-1:0] CODE_FULL  = 8'h00;
   localparam logic [CHAR_W-1:0] CODE_DEL   = 8'h7F;
   localparam logic [CHAR_W-1:0] CODE_CLEAR = 8'h0C;
   localparam logic [CHAR_W-1:0] CODE_HOME  = 8'h14;
   localparam logic [CHAR_W-1:0] CODE_CR    = 8'h0D;
   localparam logic [CHAR_W-1:0] CODE_ESC   = 8'h1B;
   localparam logic [CHAR_W-1:0] CODE_UP    = 8'h41;
   localparam logic [CHAR_W-1:0] CODE_DOWN  = 8'h42;
   localparam logic [CHAR_W-1:0] CODE_RIGHT = 8'h43;
   localparam logic [CHAR_W-1:0] CODE_LEFT  = 8'h44;
   localparam logic [CHAR_W-1:0] GLYPH      = 8'hFF;
   localparam logic [CHAR_W-1:0] SPACE      = 8'h20;

   // escape phases
   localparam logic [PHASE_W-1:0] PH_NORMAL = 2'd0;
   localparam logic [PHASE_W-1:0] PH_ESC    = 2'd1;
   localparam logic [PHASE_W-1:0] PH_ARROW  = 2'd2;

   // register reset values and indexes
   localparam logic [CSR_W-1:0] BLINK_RESET = 8'd30;
   localparam logic [CSR_W-1:0] HOLD_RESET  = 8'd15;
   localparam logic [CSR_W-1:0] COUNT_RESET = 8'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BLINK_HALF = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_HOLD   = 1'd1;

   typedef enum logic [3:0] {
      ST_INIT,
      ST_IDLE,
      ST_ROUTE,
      ST_WR_OLD,
      ST_WR_SPACE,
      ST_CLEAR,
      ST_PLACE_RD,
      ST_PLACE_WR,
      ST_BLINK_RD,
      ST_BLINK_WR,
      ST_OUT_RD,
      ST_OUT_WAIT
   } state_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_FULL,
      OP_PRINT,
      OP_DEL,
      OP_CLEAR,
      OP_HOME,
      OP_CR,
      OP_ARROW_MOVE,
      OP_ARROW_STAY
   } op_type;

   typedef enum logic [2:0] {
      WR_NONE,
      WR_OLD,
      WR_SPACE,
      WR_GLYPH,
      WR_TOGGLE,
      WR_CLEAR
   } wr_sel_type;

   typedef enum logic [1:0] {
      RD_NONE,
      RD_CURSOR,
      RD_OUT
   } rd_sel_type;

   typedef struct packed {
      logic       accept;
      logic       move;
      wr_sel_type wr_sel;
      rd_sel_type rd_sel;
      logic       save;
      logic       load_rsp;
   } ctrl_cmd_type;

   typedef struct packed {
      op_type op;
      logic   toggle;
      logic   clr_last;
      logic   out_free;
   } ctrl_status_type;

endpackage

// ----- rtl/text_terminal_cursor_editor.sv -----
// Top level of the text terminal cursor editor: stream ports and packing.
// Depends on tce_pkg, tce_ctrl, tce_datapath (and through it tce_ram).
//
// One request word per video frame drives one edit of a 32 x 30 character
// screen held in a RAM with one write port and one registered read port. A
// word may carry a received byte (tuser high). The block then prints the
// byte, or acts on full block, backspace, clear screen, home, carriage
// return or an ESC [ A/B/C/D arrow sequence. It keeps a blinking 0xFF cursor
// glyph over the saved character and reads one cell back. Every request
// gives exactly one response word. A word passes from its accept to its
// response through the RAM port sequence: a routing step, an optional
// write of the old cell, an optional space write (backspace), a read and
// glyph write at the cursor when the cursor is placed, a read and write for
// a blink toggle, then the read-back: a RAM read and a wait for the output
// register. Clear screen replaces the old-cell write with a sweep that
// writes one cell per cycle over all 960 cells. The sequencer then returns
// to idle, where it takes the next word. After reset the same sweep zeroes
// the RAM, so req_tready stays low until every cell is written;
// configuration writes are taken at any time. A finished response sits in
// an output register, so the next request is taken while it waits; the
// sequencer holds only if a second response is ready before the first one
// leaves.
module text_terminal_cursor_editor (
   input  logic                          clock,
   input  logic                          reset,
   // request stream
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [tce_pkg::REQ_W-1:0]     req_tdata,   // rx_byte[7:0], read_addr[17:8],
                                                      // zero[23:18]
   input  logic                          req_tuser,   // byte_valid[0]
   // response stream
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [tce_pkg::RSP_W-1:0]     rsp_tdata,   // cursor_pos[9:0], escape_state[11:10],
                                                      // read_char[19:12], zero[23:20]
   // register writes
   input  logic                          csr_we,
   input  logic [tce_pkg::CSR_IDX_W-1:0] csr_addr,
   input  logic [tce_pkg::CSR_W-1:0]     csr_wdata
);
   import tce_pkg::*;

   ctrl_cmd_type       cmd;
   ctrl_status_type    status;
   logic [ADDR_W-1:0]  cursor_pos;
   logic [PHASE_W-1:0] escape_state;
   logic [CHAR_W-1:0]  read_char;

   // sequencer: owns the request handshake and steps the RAM accesses
   tce_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .status    (status),
      .cmd       (cmd)
   );

   // unpack the request word straight into the datapath
   tce_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .csr_we      (csr_we),
      .csr_addr    (csr_addr),
      .csr_wdata   (csr_wdata),
      .byte_valid  (req_tuser),
      .rx_byte     (req_tdata[CHAR_W-1:0]),
      .read_addr   (req_tdata[CHAR_W +: ADDR_W]),
      .rsp_tready  (rsp_tready),
      .rsp_valid   (rsp_tvalid),
      .cursor_pos  (cursor_pos),
      .escape_state(escape_state),
      .read_char   (read_char)
   );

   // pack the response word, lowest field first, zero fill to whole bytes
   assign rsp_tdata = {(RSP_W - ADDR_W - PHASE_W - CHAR_W)'(0),
                       read_char, escape_state, cursor_pos};

endmodule

// ----- rtl/tce_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tce_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 960
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ----- rtl/tce_ctrl.sv -----
// Sequencer of the cursor editor: walks one item through the screen RAM steps.
// Depends on tce_pkg.
module tce_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  tce_pkg::ctrl_status_type status,
   output tce_pkg::ctrl_cmd_type    cmd
);
   import tce_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_INIT: begin
            if (status.clr_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_tvalid) state_in = ST_ROUTE;
         end
         ST_ROUTE: begin
            unique case (status.op)
               OP_NONE:       state_in = status.toggle ? ST_BLINK_RD : ST_OUT_RD;
               OP_CLEAR:      state_in = ST_CLEAR;
               OP_ARROW_STAY: state_in = ST_PLACE_RD;
               default:       state_in = ST_WR_OLD;
            endcase
         end
         ST_WR_OLD: begin
            state_in = (status.op == OP_DEL) ? ST_WR_SPACE : ST_PLACE_RD;
         end
         ST_WR_SPACE: state_in = ST_PLACE_RD;
         ST_CLEAR: begin
            if (status.clr_last) state_in = ST_PLACE_RD;
         end
         ST_PLACE_RD: state_in = ST_PLACE_WR;
         ST_PLACE_WR: state_in = status.toggle ? ST_BLINK_RD : ST_OUT_RD;
         ST_BLINK_RD: state_in = ST_BLINK_WR;
         ST_BLINK_WR: state_in = ST_OUT_RD;
         ST_OUT_RD:   state_in = ST_OUT_WAIT;
         ST_OUT_WAIT: begin
            if (status.out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_INIT;
      endcase
   end

   // outputs
   always_comb begin
      cmd        = '{accept: 1'b0, move: 1'b0, wr_sel: WR_NONE, rd_sel: RD_NONE,
                     save: 1'b0, load_rsp: 1'b0};
      req_tready = 1'b0;
      unique case (state_ff)
         ST_INIT:     cmd.wr_sel = WR_CLEAR;
         ST_IDLE: begin
            req_tready = 1'b1;
            cmd.accept = req_tvalid;
         end
         ST_ROUTE:    cmd.move = (status.op == OP_CLEAR);
         ST_WR_OLD: begin
            cmd.wr_sel = WR_OLD;
            cmd.move   = 1'b1;
         end
         ST_WR_SPACE: cmd.wr_sel = WR_SPACE;
         ST_CLEAR:    cmd.wr_sel = WR_CLEAR;
         ST_PLACE_RD: cmd.rd_sel = RD_CURSOR;
         ST_PLACE_WR: begin
            cmd.wr_sel = WR_GLYPH;
            cmd.save   = 1'b1;
         end
         ST_BLINK_RD: cmd.rd_sel = RD_CURSOR;
         ST_BLINK_WR: cmd.wr_sel = WR_TOGGLE;
         ST_OUT_RD:   cmd.rd_sel = RD_OUT;
         ST_OUT_WAIT: cmd.load_rsp = status.out_free;
         default: ;
      endcase
   end

endmodule

// ----- rtl/tce_datapath.sv -----
// Datapath of the cursor editor: cursor, escape phase, blink counter,
// configuration registers, screen RAM and result register. Depends on tce_pkg, tce_ram.
module tce_datapath (
   input  logic                              clock,
   input  logic                              reset,
   input  tce_pkg::ctrl_cmd_type             cmd,
   output tce_pkg::ctrl_status_type          status,
   input  logic                              csr_we,
   input  logic [tce_pkg::CSR_IDX_W-1:0]     csr_addr,
   input  logic [tce_pkg::CSR_W-1:0]         csr_wdata,
   input  logic                              byte_valid,
   input  logic [tce_pkg::CHAR_W-1:0]        rx_byte,
   input  logic [tce_pkg::ADDR_W-1:0]        read_addr,
   input  logic                              rsp_tready,
   output logic                              rsp_valid,
   output logic [tce_pkg::ADDR_W-1:0]        cursor_pos,
   output logic [tce_pkg::PHASE_W-1:0]       escape_state,
   output logic [tce_pkg::CHAR_W-1:0]        read_char
);
   import tce_pkg::*;

   logic [CSR_W-1:0]   half_ff, hold_ff, count_ff, count_in;
   logic [CSR_W-1:0]   count_pre;
   logic [ROW_W-1:0]   row_ff, row_in;
   logic [COL_W-1:0]   col_ff, col_in;
   logic [CHAR_W-1:0]  saved_ff;
   logic [PHASE_W-1:0] phase_ff, phase_in;
   logic [CHAR_W-1:0]  byte_ff;
   logic [ADDR_W-1:0]  raddr_ff;
   op_type             op_ff, op_in;
   logic               toggle_ff;
   logic [CELL_W-1:0]  clr_ff;
   logic               clr_last;
   logic               rsp_valid_ff;
   logic [ADDR_W-1:0]  pos_ff;
   logic [PHASE_W-1:0] state_ff;
   logic [CHAR_W-1:0]  char_ff;
   logic               raddr_ok_ff;
   logic               out_free;

   logic [CELL_W-1:0]  cur_addr;
   logic               row_last, col_last;
   logic               ram_we, ram_re;
   logic [CELL_W-1:0]  ram_waddr, ram_raddr;
   logic [CHAR_W-1:0]  ram_wdata, ram_rdata;

   assign cur_addr = CELL_W'(CELL_W'(row_ff) * CELL_W'(COLUMNS)) + CELL_W'(col_ff);
   assign row_last = (row_ff == ROW_W'(ROWS - 1));
   assign col_last = (col_ff == COL_W'(COLUMNS - 1));
   assign clr_last = (clr_ff == CELL_W'(CELLS - 1));
   assign out_free = !rsp_valid_ff || rsp_tready;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         half_ff <= BLINK_RESET;
         hold_ff <= HOLD_RESET;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_BLINK_HALF: half_ff <= csr_wdata;
            CSR_KEY_HOLD:   hold_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // decode of an incoming word: operation, next phase, blink count
   always_comb begin
      op_in    = OP_NONE;
      phase_in = phase_ff;
      if (byte_valid) begin
         unique case (phase_ff)
            PH_NORMAL: begin
               unique case (rx_byte)
                  CODE_FULL:  op_in = OP_FULL;
                  CODE_DEL:   op_in = OP_DEL;
                  CODE_CLEAR: op_in = OP_CLEAR;
                  CODE_HOME:  op_in = OP_HOME;
                  CODE_CR:    op_in = OP_CR;
                  CODE_ESC: begin
                     op_in    = OP_NONE;
                     phase_in = PH_ESC;
                  end
                  default:    op_in = OP_PRINT;
               endcase
            end
            PH_ESC: phase_in = PH_ARROW;
            PH_ARROW: begin
               phase_in = PH_NORMAL;
               if (rx_byte == CODE_UP || rx_byte == CODE_DOWN ||
                   rx_byte == CODE_RIGHT || rx_byte == CODE_LEFT) begin
                  op_in = OP_ARROW_MOVE;
               end else begin
                  op_in = OP_ARROW_STAY;
               end
            end
            default: phase_in = PH_NORMAL;
         endcase
      end
      count_pre = byte_valid ? hold_ff : (count_ff - CSR_W'(1));
      count_in  = (count_pre == '0) ? half_ff : count_pre;
   end

   // cursor move for the held operation
   always_comb begin
      row_in = row_ff;
      col_in = col_ff;
      unique case (op_ff)
         OP_FULL, OP_PRINT: begin
            if (col_last) begin
               col_in = '0;
               row_in = row_last ? '0 : row_ff + ROW_W'(1);
            end else begin
               col_in = col_ff + COL_W'(1);
            end
         end
         OP_DEL: begin
            if (col_ff != '0) begin
               col_in = col_ff - COL_W'(1);
            end else if (row_ff != '0) begin
               col_in = COL_W'(COLUMNS - 1);
               row_in = row_ff - ROW_W'(1);
            end
         end
         OP_CLEAR, OP_HOME: begin
            row_in = '0;
            col_in = '0;
         end
         OP_CR: begin
            col_in = '0;
            row_in = row_last ? '0 : row_ff + ROW_W'(1);
         end
         OP_ARROW_MOVE: begin
            unique if (byte_ff == CODE_UP) begin
               row_in = (row_ff == '0) ? ROW_W'(ROWS - 1) : row_ff - ROW_W'(1);
            end else if (byte_ff == CODE_DOWN) begin
               row_in = row_last ? '0 : row_ff + ROW_W'(1);
            end else if (byte_ff == CODE_RIGHT) begin
               col_in = col_last ? '0 : col_ff + COL_W'(1);
            end else begin
               col_in = (col_ff == '0) ? COL_W'(COLUMNS - 1) : col_ff - COL_W'(1);
            end
         end
         default: ;
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff       <= '0;
         col_ff       <= '0;
         saved_ff     <= GLYPH;
         phase_ff     <= PH_NORMAL;
         count_ff     <= COUNT_RESET;
         op_ff        <= OP_NONE;
         toggle_ff    <= 1'b0;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.accept) begin
            op_ff     <= op_in;
            phase_ff  <= phase_in;
            count_ff  <= count_in;
            toggle_ff <= (count_pre == '0);
         end
         if (cmd.move) begin
            row_ff <= row_in;
            col_ff <= col_in;
         end
         if (cmd.save) begin
            saved_ff <= ram_rdata;
         end
         if (cmd.wr_sel == WR_CLEAR) begin
            clr_ff <= clr_last ? '0 : clr_ff + CELL_W'(1);
         end
         if (cmd.load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // item and result payload
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         byte_ff     <= rx_byte;
         raddr_ff    <= read_addr;
         raddr_ok_ff <= (int'(read_addr) < CELLS);
      end
      if (cmd.load_rsp) begin
         pos_ff   <= ADDR_W'(cur_addr);
         state_ff <= phase_ff;
         char_ff  <= raddr_ok_ff ? ram_rdata : '0;
      end
   end

   // RAM port steering
   always_comb begin
      ram_we    = 1'b1;
      ram_waddr = cur_addr;
      ram_wdata = GLYPH;
      unique case (cmd.wr_sel)
         WR_NONE:  ram_we = 1'b0;
         WR_OLD: begin
            unique case (op_ff)
               OP_FULL:  ram_wdata = GLYPH;
               OP_PRINT: ram_wdata = byte_ff;
               default:  ram_wdata = saved_ff;
            endcase
         end
         WR_SPACE:  ram_wdata = SPACE;
         WR_GLYPH:  ram_wdata = GLYPH;
         WR_TOGGLE: ram_wdata = (ram_rdata == GLYPH) ? saved_ff : GLYPH;
         WR_CLEAR: begin
            ram_waddr = clr_ff;
            ram_wdata = '0;
         end
         default:   ram_we = 1'b0;
      endcase
      ram_re    = (cmd.rd_sel != RD_NONE);
      ram_raddr = (cmd.rd_sel == RD_OUT) ? CELL_W'(raddr_ff) : cur_addr;
   end

   tce_ram #(
      .WIDTH(CHAR_W),
      .DEPTH(CELLS)
   ) u_screen (
      .clock(clock),
      .we   (ram_we),
      .waddr(ram_waddr),
      .wdata(ram_wdata),
      .re   (ram_re),
      .raddr(ram_raddr),
      .rdata(ram_rdata)
   );

   assign status = '{op: op_ff, toggle: toggle_ff, clr_last: clr_last, out_free: out_free};

   assign rsp_valid    = rsp_valid_ff;
   assign cursor_pos   = pos_ff;
   assign escape_state = state_ff;
   assign read_char    = char_ff;

endmodule

// ----- test/text_terminal_cursor_editor_test.sv -----
// Self-checking bench for the text terminal cursor editor: request words are
// replayed on a local mirror of the screen, cursor and blink state.
// Depends on tce_pkg and the text_terminal_cursor_editor RTL.
module text_terminal_cursor_editor_test;
   import tce_pkg::*;

   localparam int CYCLE_LIMIT   = 500000;
   localparam int SETTLE_CYCLES = 20;
   localparam int MAX_REPORTS   = 10;
   localparam int IDLE_PERCENT  = 20;
   localparam logic [CHAR_W-1:0] BRACKET = 8'h5B;

   // one response word, cursor in the low bits as on rsp_tdata
   typedef struct packed {
      logic [CHAR_W-1:0]  cell_char;
      logic [PHASE_W-1:0] phase;
      logic [ADDR_W-1:0]  cursor;
   } screen_view_type;

   logic                 clock;
   logic                 reset;
   logic                 req_tvalid;
   logic                 req_tready;
   logic [REQ_W-1:0]     req_tdata;
   logic                 req_tuser;
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [RSP_W-1:0]     rsp_tdata;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_addr;
   logic [CSR_W-1:0]     csr_wdata;

   // mirror of the block state
   logic [CHAR_W-1:0]  screen_mirror [CELLS];
   int                 cursor_mirror;
   logic [CHAR_W-1:0]  covered_char;
   logic [PHASE_W-1:0] esc_phase;
   logic [CSR_W-1:0]   blink_count;
   logic [CSR_W-1:0]   blink_half;
   logic [CSR_W-1:0]   key_hold;

   screen_view_type pending_views [$];
   int mismatches     = 0;
   int frames_sent    = 0;
   int cycle_count    = 0;
   int receiver_hold  = 0;
   bit steady_flow    = 1'b0;

   text_terminal_cursor_editor dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Bound the run; a hang in either handshake ends here.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // Receiver: a requested hold-off is counted down here, otherwise idle at
   // random unless the steady stretch is on.
   always @(posedge clock) begin
      if (receiver_hold > 0) begin
         rsp_tready <= 1'b0;
         receiver_hold = receiver_hold - 1;
      end else if (steady_flow || reset) begin
         rsp_tready <= 1'b1;
      end else begin
         rsp_tready <= ($urandom_range(99) >= IDLE_PERCENT);
      end
   end

   task automatic compare_field(input string field, input int want, input int got);
      if (want != got) begin
         mismatches++;
         if (mismatches <= MAX_REPORTS)
            $display("%s mismatch: expected %0d, got %0d", field, want, got);
      end
   endtask

   // Match each response word against the oldest expected view.
   always @(posedge clock) begin : check_words
      screen_view_type want;
      screen_view_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata[CHAR_W+PHASE_W+ADDR_W-1:0];
         if (pending_views.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("response word %h with nothing expected", rsp_tdata);
         end else begin
            want = pending_views.pop_front();
            compare_field("cursor_pos", want.cursor, got.cursor);
            compare_field("escape_state", want.phase, got.phase);
            compare_field("read_char", want.cell_char, got.cell_char);
         end
      end
   end

   // Advance the mirror by one frame tick and return the view it should show.
   task automatic apply_frame(input bit has_byte, input logic [CHAR_W-1:0] code,
                              input logic [ADDR_W-1:0] addr, output screen_view_type view);
      int col;
      bit place;
      place = 1'b0;
      blink_count = blink_count - 8'd1;
      if (has_byte) begin
         if (esc_phase == PH_NORMAL) begin
            place = 1'b1;
            case (code)
               CODE_FULL: begin
                  screen_mirror[cursor_mirror] = GLYPH;
                  cursor_mirror++;
               end
               CODE_DEL: begin
                  screen_mirror[cursor_mirror] = covered_char;
                  if (cursor_mirror > 0)
                     cursor_mirror--;
                  screen_mirror[cursor_mirror] = SPACE;
               end
               CODE_CLEAR: begin
                  foreach (screen_mirror[i])
                     screen_mirror[i] = '0;
                  cursor_mirror = 0;
               end
               CODE_HOME: begin
                  screen_mirror[cursor_mirror] = covered_char;
                  cursor_mirror = 0;
               end
               CODE_CR: begin
                  screen_mirror[cursor_mirror] = covered_char;
                  cursor_mirror = cursor_mirror - cursor_mirror % COLUMNS + COLUMNS;
               end
               CODE_ESC: begin
                  // no cursor placement until the sequence ends
                  esc_phase = PH_ESC;
                  place = 1'b0;
               end
               default: begin
                  screen_mirror[cursor_mirror] = code;
                  cursor_mirror++;
               end
            endcase
         end else if (esc_phase == PH_ARROW) begin
            col = cursor_mirror % COLUMNS;
            if (code == CODE_UP || code == CODE_DOWN || code == CODE_RIGHT || code == CODE_LEFT)
               screen_mirror[cursor_mirror] = covered_char;
            case (code)
               CODE_UP:    cursor_mirror = (cursor_mirror + CELLS - COLUMNS) % CELLS;
               CODE_DOWN:  cursor_mirror = (cursor_mirror + COLUMNS) % CELLS;
               CODE_RIGHT: cursor_mirror = cursor_mirror - col + (col + 1) % COLUMNS;
               CODE_LEFT:  cursor_mirror = cursor_mirror - col + (col + COLUMNS - 1) % COLUMNS;
               default: ;
            endcase
            // any letter ends the sequence; the cell is saved again as it is
            esc_phase = PH_NORMAL;
            place = 1'b1;
         end else begin
            esc_phase = PH_ARROW;
         end
         if (place) begin
            // wrap past the last cell before placing the glyph
            if (cursor_mirror >= CELLS)
               cursor_mirror = 0;
            covered_char = screen_mirror[cursor_mirror];
            screen_mirror[cursor_mirror] = GLYPH;
         end
         blink_count = key_hold;
      end
      if (blink_count == 8'd0) begin
         blink_count = blink_half;
         screen_mirror[cursor_mirror] = (screen_mirror[cursor_mirror] == GLYPH) ?
                                        covered_char : GLYPH;
      end
      view.cursor    = ADDR_W'(cursor_mirror);
      view.phase     = esc_phase;
      view.cell_char = (addr < CELLS) ? screen_mirror[addr] : '0;
   endtask

   // Offer one request word, optionally after a random gap, and log its view.
   task automatic send_frame(input bit has_byte, input logic [CHAR_W-1:0] code,
                             input logic [ADDR_W-1:0] addr);
      screen_view_type view;
      if (!steady_flow && $urandom_range(99) < IDLE_PERCENT) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= has_byte;
      req_tdata  <= {{(REQ_W-CHAR_W-ADDR_W){1'b0}}, addr, code};
      do @(posedge clock); while (!req_tready);
      apply_frame(has_byte, code, addr, view);
      pending_views.push_back(view);
      frames_sent++;
   endtask

   // Mostly read near the cursor where the edits happen; sometimes beyond the store.
   function automatic logic [ADDR_W-1:0] pick_addr();
      int pick;
      pick = $urandom_range(99);
      if (pick < 55)
         return ADDR_W'(cursor_mirror + $urandom_range(4) - 2);
      else if (pick < 90)
         return ADDR_W'($urandom_range(CELLS - 1));
      else
         return ADDR_W'($urandom_range((1 << ADDR_W) - 1));
   endfunction

   task automatic send_escape(input logic [CHAR_W-1:0] opener, input logic [CHAR_W-1:0] letter);
      send_frame(1'b1, CODE_ESC, pick_addr());
      send_frame(1'b1, opener, pick_addr());
      send_frame(1'b1, letter, pick_addr());
   endtask

   // Stop offering, wait for every expected word, then let the block settle.
   task automatic drain();
      req_tvalid <= 1'b0;
      while (pending_views.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] index, input logic [CSR_W-1:0] value);
      drain();
      csr_we    <= 1'b1;
      csr_addr  <= index;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
      if (index == CSR_BLINK_HALF)
         blink_half = value;
      else
         key_hold = value;
   endtask

   task automatic random_item();
      int pick;
      logic [CHAR_W-1:0] opener;
      logic [CHAR_W-1:0] letter;
      pick = $urandom_range(999);
      if (pick < 5) begin
         send_frame(1'b1, CODE_CLEAR, pick_addr());
      end else if (pick < 300) begin
         send_frame(1'b1, CHAR_W'($urandom_range(8'h20, 8'h7E)), pick_addr());
      end else if (pick < 400) begin
         send_frame(1'b1, CHAR_W'($urandom_range(8'hFF)), pick_addr());
      end else if (pick < 550) begin
         // tick without a byte; data lines carry noise
         send_frame(1'b0, CHAR_W'($urandom_range(8'hFF)), pick_addr());
      end else if (pick < 700) begin
         case ($urandom_range(3))
            0: letter = CODE_FULL;
            1: letter = CODE_DEL;
            2: letter = CODE_HOME;
            default: letter = CODE_CR;
         endcase
         send_frame(1'b1, letter, pick_addr());
      end else if (pick < 950) begin
         case ($urandom_range(3))
            0: letter = CODE_UP;
            1: letter = CODE_DOWN;
            2: letter = CODE_RIGHT;
            default: letter = CODE_LEFT;
         endcase
         opener = BRACKET;
         // break some sequences in either position
         if ($urandom_range(9) == 0)
            opener = CHAR_W'($urandom_range(8'hFF));
         if ($urandom_range(9) == 0)
            letter = CHAR_W'($urandom_range(8'hFF));
         send_escape(opener, letter);
      end else begin
         // lone escape; the next two bytes, whatever they are, finish the sequence
         send_frame(1'b1, CODE_ESC, pick_addr());
      end
   endtask

   // First blink toggles cell 0 at once; reads at the first and last cells and beyond the store.
   task automatic test_power_up_reads();
      send_frame(1'b0, 8'h00, 10'd0);
      send_frame(1'b0, 8'hFF, 10'd959);
      send_frame(1'b0, 8'h5A, 10'd1023);
   endtask

   task automatic test_edit_codes();
      send_frame(1'b1, 8'h61, 10'd0);
      send_frame(1'b1, 8'hFF, 10'd1);       // glyph code printed as text
      send_frame(1'b1, CODE_FULL, 10'd2);
      send_frame(1'b1, CODE_DEL, 10'd2);
      send_frame(1'b1, CODE_HOME, 10'd2);
      send_frame(1'b1, CODE_DEL, 10'd0);    // backspace at the first cell stays put
      send_frame(1'b1, CODE_CR, 10'd32);
   endtask

   task automatic test_arrow_wrap();
      send_escape(BRACKET, CODE_UP);        // back to the top row
      send_escape(BRACKET, CODE_UP);        // wrap to the last row
      send_escape(BRACKET, CODE_LEFT);      // wrap to the last cell
      send_frame(1'b1, 8'h7A, 10'd959);     // print past the last cell, wrap home
      send_escape(BRACKET, CODE_LEFT);
      send_escape(BRACKET, CODE_RIGHT);
      send_escape(BRACKET, CODE_DOWN);
      send_frame(1'b1, CODE_ESC, 10'd32);   // escape, escape, then a non-arrow letter
      send_frame(1'b1, CODE_ESC, 10'd32);
      send_frame(1'b1, 8'h51, 10'd32);
      send_frame(1'b1, CODE_CLEAR, 10'd32);
      send_frame(1'b0, 8'h00, 10'd0);
   endtask

   // Fill the block while the receiver holds off, then pause the sender
   // until it empties, then run a stretch with no idling at all.
   task automatic test_receiver_hold_off();
      int target;
      drain();
      steady_flow = 1'b0;
      receiver_hold = 300;
      target = frames_sent + 16;
      while (frames_sent < target) random_item();
      drain();
      steady_flow = 1'b1;
      target = frames_sent + 60;
      while (frames_sent < target) random_item();
      drain();
      steady_flow = 1'b0;
   endtask

   task automatic test_random_traffic();
      int target;
      for (int phase_idx = 0; phase_idx < 6; phase_idx++) begin
         case (phase_idx)
            0: begin
               write_reg(CSR_BLINK_HALF, 8'd1);
               write_reg(CSR_KEY_HOLD, 8'd1);
            end
            1: begin
               write_reg(CSR_BLINK_HALF, 8'd3);
               write_reg(CSR_KEY_HOLD, 8'd2);
            end
            2: begin
               write_reg(CSR_BLINK_HALF, 8'd255);
               write_reg(CSR_KEY_HOLD, 8'd255);
            end
            3: begin
               // zero hold toggles in the same frame; zero half period waits 256
               write_reg(CSR_BLINK_HALF, 8'd0);
               write_reg(CSR_KEY_HOLD, 8'd0);
            end
            4: begin
               write_reg(CSR_BLINK_HALF, 8'd1);
               write_reg(CSR_KEY_HOLD, 8'd255);
            end
            default: begin
               write_reg(CSR_BLINK_HALF, BLINK_RESET);
               write_reg(CSR_KEY_HOLD, HOLD_RESET);
            end
         endcase
         steady_flow = (phase_idx == 2);
         target = frames_sent + 205;
         while (frames_sent < target) random_item();
      end
      steady_flow = 1'b0;
   endtask

   initial begin
      clock      = 1'b0;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = 1'b0;
      csr_we     = 1'b0;
      csr_addr   = '0;
      csr_wdata  = '0;
      foreach (screen_mirror[i])
         screen_mirror[i] = '0;
      cursor_mirror = 0;
      covered_char  = GLYPH;
      esc_phase     = PH_NORMAL;
      blink_count   = COUNT_RESET;
      blink_half    = BLINK_RESET;
      key_hold      = HOLD_RESET;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      test_power_up_reads();
      test_edit_codes();
      test_arrow_wrap();
      test_receiver_hold_off();
      test_random_traffic();
      drain();

      if (mismatches == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
